// ===== src/bbea_pkg.sv =====
`timescale 1ns / 1ps
package bbea_pkg;

	localparam int REF_MAX_DEF = 32;
	localparam int DW          = 5;	// distance width
	localparam int LW          = 7;	// reference length width, holds REF_MAX itself
	localparam int CW          = 8;	// character width

	localparam logic [2:0] REG_BLIM = 3'd0;
	localparam logic [2:0] REG_ALIM = 3'd1;
	localparam logic [2:0] REG_SPAN = 3'd2;
	localparam logic [2:0] REG_RLEN = 3'd3;
	localparam logic [2:0] REG_REF0 = 3'd4;
	localparam logic [2:0] REG_REF1 = 3'd5;
	localparam logic [2:0] REG_REF2 = 3'd6;
	localparam logic [2:0] REG_REF3 = 3'd7;

	localparam logic [DW-1:0] SAT = 5'd31;

	// wavefront token handed from cell to cell
	typedef struct packed {
		logic          valid;
		logic          upd;
		logic          last;
		logic [CW-1:0] ch;
		logic [DW-1:0] left;
		logic [DW-1:0] diag;
		logic [DW-1:0] bd;
		logic          give_up;
		logic          sat;
	} tok_t;

	typedef struct packed {
		logic [DW-1:0] alim;
		logic [DW-1:0] blim;
		logic [LW-1:0] bc;
		logic [LW-1:0] len;
	} cfg_t;

	typedef struct packed {
		logic [DW-1:0]        blim;
		logic [DW-1:0]        alim;
		logic [5:0]           span;
		logic [5:0]           rlen;
		logic [3:0][63:0]     refc;
	} regs_t;

endpackage

// ===== src/bbea_regs.sv =====
`timescale 1ns / 1ps
module bbea_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [5:0]         paddr,
	input  logic [63:0]        pwdata,
	output logic [63:0]        prdata,
	output logic               pready,
	output bbea_pkg::regs_t    regs
);
	import bbea_pkg::*;

	regs_t regs_q;
	logic  wr;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;
	assign regs   = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.blim <= 5'd2;
			regs_q.alim <= 5'd4;
			regs_q.span <= 6'd8;
			regs_q.rlen <= 6'd16;
			regs_q.refc <= '0;
		end else if (wr) begin
			unique case (paddr[5:3])
				REG_BLIM: regs_q.blim    <= pwdata[4:0];
				REG_ALIM: regs_q.alim    <= pwdata[4:0];
				REG_SPAN: regs_q.span    <= pwdata[5:0];
				REG_RLEN: regs_q.rlen    <= pwdata[5:0];
				REG_REF0: regs_q.refc[0] <= pwdata;
				REG_REF1: regs_q.refc[1] <= pwdata;
				REG_REF2: regs_q.refc[2] <= pwdata;
				REG_REF3: regs_q.refc[3] <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[5:3])
			REG_BLIM: prdata = {59'd0, regs_q.blim};
			REG_ALIM: prdata = {59'd0, regs_q.alim};
			REG_SPAN: prdata = {58'd0, regs_q.span};
			REG_RLEN: prdata = {58'd0, regs_q.rlen};
			REG_REF0: prdata = regs_q.refc[0];
			REG_REF1: prdata = regs_q.refc[1];
			REG_REF2: prdata = regs_q.refc[2];
			REG_REF3: prdata = regs_q.refc[3];
			default:  prdata = '0;
		endcase
	end

endmodule

// ===== src/bbea_cell.sv =====
`timescale 1ns / 1ps
module bbea_cell #(
	parameter int IDX = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bbea_pkg::tok_t     tok_in,
	input  logic [7:0]         ref_ch,
	input  bbea_pkg::cfg_t     cfg,
	input  logic               clr,
	output bbea_pkg::tok_t     nxt,
	output bbea_pkg::tok_t     tok_out
);
	import bbea_pkg::*;

	localparam logic [LW-1:0] IDX_L  = LW'(IDX);
	localparam logic [LW-1:0] IDX_L1 = LW'(IDX + 1);
	localparam logic [DW-1:0] DRST   = (IDX + 1 > 31) ? SAT : DW'(IDX + 1);

	logic [DW-1:0] dist_q, cmin_q;
	tok_t          tok_q;
	logic [DW-1:0] up, v, m, cmin_nx;
	logic [DW:0]   c1, c2, c3, a6, v6;
	logic          in_bc, ok;

	always_comb begin
		up = (dist_q < cfg.alim) ? dist_q : cfg.alim;
		c1 = {1'b0, up} + 6'd1;
		c2 = {1'b0, tok_in.left} + 6'd1;
		c3 = {1'b0, tok_in.diag} + {5'd0, (ref_ch != tok_in.ch)};
		a6 = {1'b0, cfg.alim};
		v6 = (c1 < c2) ? c1 : c2;
		v6 = (c3 < v6) ? c3 : v6;
		v6 = (a6 < v6) ? a6 : v6;
		v  = v6[DW-1:0];
		cmin_nx = (v < cmin_q) ? v : cmin_q;
		m  = tok_in.upd ? cmin_nx : cmin_q;
		in_bc = IDX_L < cfg.bc;
		ok = (m < cfg.alim) && (m < cfg.blim);

		nxt = tok_in;
		if (tok_in.upd) begin
			nxt.left = v;
			nxt.diag = up;
		end
		if (in_bc) begin
			nxt.bd      = ok ? m : cfg.blim;
			nxt.give_up = tok_in.give_up | ~ok;
		end
		nxt.sat = tok_in.sat | (m >= cfg.alim);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q <= DRST;
			cmin_q <= SAT;
		end else if (clr) begin
			dist_q <= DRST;
			cmin_q <= SAT;
		end else if (tok_in.valid && tok_in.upd) begin
			dist_q <= v;
			cmin_q <= cmin_nx;
		end
	end

	// hand the wavefront on; it stops at the last reference column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q       <= nxt;
			tok_q.valid <= tok_in.valid && (IDX_L1 < cfg.len);
		end
	end

	assign tok_out = tok_q;

endmodule

// ===== src/bounded_barcode_edit_align.sv =====
`timescale 1ns / 1ps
// Bounded barcode edit distance and aligned read length.
// Program the limits, barcode span, reference length and reference characters
// through the APB port (64-bit registers at byte address 8*i) while no read is
// in flight. Then stream the read in, one character per input beat, with
// read_end high on its final character. Only that final beat yields an output
// beat: barcode_distance and aligned_length.
// Each cell of the chain holds one reference column (row value and column
// minimum); a beat launches a wavefront that steps one cell per cycle. A beat
// that updates the row, or ends the read, occupies the chain until its
// wavefront leaves the last of the L columns, L being the clamped reference
// length; a beat past the length cap without read_end launches no wavefront.
// The result is registered into the output queue as that wavefront leaves.
// Results sit in a two-entry output queue: a stalled receiver does not hold
// the chain; input stalls while the chain is busy or a second result waits.
// Reset restores the default registers, clears the read state and presets every
// cell to its start-of-read boundary value; the block is ready at once.
// Each queued result likewise returns the read state to its start values.
module bounded_barcode_edit_align #(
	parameter int REF_MAX = bbea_pkg::REF_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  read_char,
	input  logic        read_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  barcode_distance,
	output logic [5:0]  aligned_length
);
	import bbea_pkg::*;

	localparam int LSW = $clog2(REF_MAX);

	regs_t         regs;
	cfg_t          cfg;
	logic [LW-1:0] rl, span_l, lm1;
	logic [7:0]    cap_sum;
	logic [5:0]    cap;
	logic [LW-1:0] rp1;
	logic [DW-1:0] diag0, left0;
	logic          upd, acc, launch, push, pop;

	tok_t          tok0_q;
	tok_t          tin   [REF_MAX];
	tok_t          nxt_a [REF_MAX];
	logic [7:0]    rc    [REF_MAX];
	tok_t          fin;

	logic [5:0]    read_pos_q;
	logic [DW-1:0] best_s_q, bs_new;
	logic [5:0]    best_l_q, bl_new;
	logic          busy_q;
	logic [DW-1:0] bd_r;
	logic [5:0]    al_r;

	logic          res0_v_q, res1_v_q;
	logic [DW-1:0] res0_bd_q, res1_bd_q;
	logic [5:0]    res0_al_q, res1_al_q;

	bbea_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.regs    (regs)
	);

	// clamp the reference length, derive barcode span and length cap
	always_comb begin
		rl = {1'b0, regs.rlen};
		if (rl == '0)
			cfg.len = LW'(1);
		else if (rl > LW'(REF_MAX))
			cfg.len = LW'(REF_MAX);
		else
			cfg.len = rl;
		span_l   = {1'b0, regs.span};
		cfg.bc   = (span_l < cfg.len) ? span_l : cfg.len;
		cfg.alim = regs.alim;
		cfg.blim = regs.blim;
		cap_sum  = {1'b0, cfg.len} + {3'd0, regs.alim};
		cap      = (cap_sum > 8'd63) ? 6'd63 : cap_sum[5:0];
		lm1      = cfg.len - LW'(1);
	end

	// row boundary for this read character
	always_comb begin
		upd   = read_pos_q < cap;
		diag0 = (read_pos_q >= {1'b0, regs.alim}) ? regs.alim : read_pos_q[DW-1:0];
		rp1   = {1'b0, read_pos_q} + LW'(1);
		left0 = (rp1 >= {2'b0, regs.alim}) ? regs.alim : rp1[DW-1:0];
	end

	assign in_stall = busy_q | res1_v_q;
	assign acc      = in_valid & ~in_stall;
	assign launch   = acc & (upd | read_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok0_q <= '0;
		end else begin
			tok0_q.valid   <= launch;
			tok0_q.upd     <= upd;
			tok0_q.last    <= read_end;
			tok0_q.ch      <= read_char;
			tok0_q.left    <= left0;
			tok0_q.diag    <= diag0;
			tok0_q.bd      <= regs.blim;
			tok0_q.give_up <= 1'b0;
			tok0_q.sat     <= 1'b0;
		end
	end

	assign tin[0] = tok0_q;

	// chain of column cells
	for (genvar j = 0; j < REF_MAX; j++) begin : g_cell
		if (j < 32) begin : g_rc
			assign rc[j] = regs.refc[j / 8][(j % 8) * 8 +: 8];
		end else begin : g_rc0
			assign rc[j] = '0;
		end
		if (j < REF_MAX - 1) begin : g_mid
			bbea_cell #(.IDX(j)) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.tok_in  (tin[j]),
				.ref_ch  (rc[j]),
				.cfg     (cfg),
				.clr     (push),
				.nxt     (nxt_a[j]),
				.tok_out (tin[j+1])
			);
		end else begin : g_end
			bbea_cell #(.IDX(j)) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.tok_in  (tin[j]),
				.ref_ch  (rc[j]),
				.cfg     (cfg),
				.clr     (push),
				.nxt     (nxt_a[j]),
				.tok_out ()
			);
		end
	end

	// the wavefront leaving the last reference column
	assign fin = nxt_a[lm1[LSW-1:0]];

	always_comb begin
		bs_new = best_s_q;
		bl_new = best_l_q;
		if (fin.upd && (fin.left < regs.alim) && (fin.left <= best_s_q)) begin
			bs_new = fin.left;
			bl_new = read_pos_q;
		end
		bd_r = fin.give_up ? regs.blim : fin.bd;
		al_r = (fin.give_up || fin.sat || (bs_new >= regs.alim)) ? 6'd0 : bl_new;
	end

	assign push = fin.valid & fin.last;
	assign pop  = res0_v_q & ~out_stall;

	// read position, best score and chain occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_pos_q <= '0;
			best_s_q   <= SAT;
			best_l_q   <= '0;
			busy_q     <= 1'b0;
		end else begin
			if (launch)
				busy_q <= 1'b1;
			else if (fin.valid)
				busy_q <= 1'b0;
			if (push)
				read_pos_q <= '0;
			else if (acc && upd)
				read_pos_q <= read_pos_q + 6'd1;
			if (push) begin
				best_s_q <= SAT;
				best_l_q <= '0;
			end else if (fin.valid) begin
				best_s_q <= bs_new;
				best_l_q <= bl_new;
			end
		end
	end

	// two-entry result queue; the second entry fills only behind a stalled head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res0_v_q <= 1'b0;
			res1_v_q <= 1'b0;
		end else if (push) begin
			if (!res0_v_q || pop)
				res0_v_q <= 1'b1;
			else
				res1_v_q <= 1'b1;
		end else if (pop) begin
			res0_v_q <= res1_v_q;
			res1_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			if (!res0_v_q || pop) begin
				res0_bd_q <= bd_r;
				res0_al_q <= al_r;
			end else begin
				res1_bd_q <= bd_r;
				res1_al_q <= al_r;
			end
		end else if (pop && res1_v_q) begin
			res0_bd_q <= res1_bd_q;
			res0_al_q <= res1_al_q;
		end
	end

	assign out_valid        = res0_v_q;
	assign barcode_distance = res0_bd_q;
	assign aligned_length   = res0_al_q;

endmodule
